// ----- design/sfcf_pkg.sv -----
// Shared types and constants for the SYN flood challenge filter.
package sfcf_pkg;

	localparam logic [15:0] FILTER_PORT = 16'd80;
	localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_DROP = 2'd1;
	localparam logic [1:0] VERDICT_CHAL = 2'd2;

	localparam logic [1:0] STAGE_NONE = 2'd0;
	localparam logic [1:0] STAGE_FIRST = 2'd1;
	localparam logic [1:0] STAGE_SENT = 2'd2;

	localparam logic [2:0] REG_SYN_SHORT = 3'd0;
	localparam logic [2:0] REG_SYN_LONG = 3'd1;
	localparam logic [2:0] REG_ACK_SHORT = 3'd2;
	localparam logic [2:0] REG_ACK_LONG = 3'd3;
	localparam logic [2:0] REG_SHORT_WIN = 3'd4;
	localparam logic [2:0] REG_LONG_WIN = 3'd5;
	localparam logic [2:0] REG_BLOCK = 3'd6;
	localparam logic [2:0] REG_CHAL_TO = 3'd7;

	// One windowed counter record.
	typedef struct packed {
		logic [20:0] count;
		logic [63:0] start;
	} counter_t;

	// One table slot (valid kept in its own memory).
	typedef struct packed {
		logic [31:0] addr;
		logic        blocked;
		logic [63:0] block_until;
		logic [1:0]  stage;
		logic [63:0] chal_time;
		logic [31:0] chal_seq;
		counter_t    syn_short;
		counter_t    syn_long;
		counter_t    ack_short;
		counter_t    ack_long;
		logic        allowed;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Register file contents.
	typedef struct packed {
		logic [19:0] syn_short_limit;
		logic [19:0] syn_long_limit;
		logic [19:0] ack_short_limit;
		logic [19:0] ack_long_limit;
		logic [47:0] short_window;
		logic [47:0] long_window;
		logic [47:0] block_ns;
		logic [47:0] chal_timeout;
	} cfg_t;

endpackage

// ----- design/sfcf_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read.
module sfcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/sfcf_regs.sv -----
// APB register file for limits and windows.
module sfcf_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	output sfcf_pkg::cfg_t cfg
);
	import sfcf_pkg::*;

	cfg_t cfg_q;
	logic [2:0] idx;

	// Registers sit on 8-byte strides.
	assign idx = paddr[5:3];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// Write registers on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.syn_short_limit <= 20'd10000;
			cfg_q.syn_long_limit <= 20'd50000;
			cfg_q.ack_short_limit <= 20'd20000;
			cfg_q.ack_long_limit <= 20'd100000;
			cfg_q.short_window <= 48'd1000000000;
			cfg_q.long_window <= 48'd16000000000;
			cfg_q.block_ns <= 48'd3600000000000;
			cfg_q.chal_timeout <= 48'd2000000000;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_SYN_SHORT: cfg_q.syn_short_limit <= pwdata[19:0];
				REG_SYN_LONG:  cfg_q.syn_long_limit <= pwdata[19:0];
				REG_ACK_SHORT: cfg_q.ack_short_limit <= pwdata[19:0];
				REG_ACK_LONG:  cfg_q.ack_long_limit <= pwdata[19:0];
				REG_SHORT_WIN: cfg_q.short_window <= pwdata[47:0];
				REG_LONG_WIN:  cfg_q.long_window <= pwdata[47:0];
				REG_BLOCK:     cfg_q.block_ns <= pwdata[47:0];
				REG_CHAL_TO:   cfg_q.chal_timeout <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SYN_SHORT: prdata = {44'd0, cfg_q.syn_short_limit};
			REG_SYN_LONG:  prdata = {44'd0, cfg_q.syn_long_limit};
			REG_ACK_SHORT: prdata = {44'd0, cfg_q.ack_short_limit};
			REG_ACK_LONG:  prdata = {44'd0, cfg_q.ack_long_limit};
			REG_SHORT_WIN: prdata = {16'd0, cfg_q.short_window};
			REG_LONG_WIN:  prdata = {16'd0, cfg_q.long_window};
			REG_BLOCK:     prdata = {16'd0, cfg_q.block_ns};
			REG_CHAL_TO:   prdata = {16'd0, cfg_q.chal_timeout};
			default: prdata = '0;
		endcase
	end
endmodule

// ----- design/sfcf_logic.sv -----
// Per-packet update of one slot record: pure combinational decision.
module sfcf_logic (
	input  sfcf_pkg::cfg_t   cfg,
	input  logic             hit,
	input  sfcf_pkg::slot_t  cur,
	input  logic [31:0]      src_addr,
	input  logic             flag_syn,
	input  logic             flag_ack,
	input  logic             flag_rst,
	input  logic [31:0]      seq_num,
	input  logic [63:0]      now,
	output sfcf_pkg::slot_t  nxt,
	output logic             wr,
	output logic [1:0]       verdict,
	output logic [31:0]      reply_ack,
	output logic             block_started
);
	import sfcf_pkg::*;

	slot_t s;
	logic done, e1, e2, over;
	counter_t c1, c2;

	// Advance one windowed counter.
	function automatic counter_t bump(counter_t c, logic [63:0] t, logic [47:0] win);
		counter_t r;
		r = c;
		if (c.count == '0 || (t - c.start) > {16'd0, win}) begin
			r.count = 21'd1;
			r.start = t;
		end else if (c.count < COUNT_MAX) begin
			r.count = c.count + 21'd1;
		end
		return r;
	endfunction

	always_comb begin
		s = cur;
		wr = 1'b0;
		done = 1'b0;
		verdict = VERDICT_PASS;
		reply_ack = '0;
		block_started = 1'b0;
		e1 = 1'b0;
		e2 = 1'b0;
		over = 1'b0;
		c1 = '0;
		c2 = '0;
		// Hold the block while it lasts.
		if (hit && s.blocked) begin
			if (now < s.block_until) begin
				verdict = VERDICT_DROP;
				done = 1'b1;
			end else begin
				s.blocked = 1'b0;
				wr = 1'b1;
			end
		end
		if (!done && flag_syn && !flag_ack) begin
			wr = 1'b1;
			if (!hit) begin
				s = '0;
				s.addr = src_addr;
			end
			if (s.stage != STAGE_NONE && (now - s.chal_time) > {16'd0, cfg.chal_timeout}
				&& s.chal_seq != seq_num) begin
				s.stage = STAGE_NONE;
			end
			priority if (s.stage == STAGE_NONE) begin
				s.stage = STAGE_FIRST;
				s.chal_time = now;
				s.chal_seq = seq_num;
				verdict = VERDICT_DROP;
			end else if (s.stage == STAGE_FIRST) begin
				s.stage = STAGE_SENT;
				s.chal_time = now;
				verdict = VERDICT_CHAL;
				reply_ack = seq_num + 32'd1;
			end else begin
				s.stage = STAGE_NONE;
				e1 = s.syn_short.count != '0;
				e2 = s.syn_long.count != '0;
				c1 = bump(s.syn_short, now, cfg.short_window);
				c2 = bump(s.syn_long, now, cfg.long_window);
				s.syn_short = c1;
				s.syn_long = c2;
				over = (e1 && c1.count > {1'b0, cfg.syn_short_limit})
					|| (e2 && c2.count > {1'b0, cfg.syn_long_limit});
				if (over) begin
					s.blocked = 1'b1;
					s.block_until = now + {16'd0, cfg.block_ns};
					verdict = VERDICT_DROP;
					block_started = 1'b1;
				end else begin
					s.allowed = 1'b1;
				end
			end
		end else if (!done && (flag_ack || flag_rst)) begin
			if (!hit || !s.allowed) begin
				verdict = VERDICT_DROP;
			end else begin
				wr = 1'b1;
				e1 = s.ack_short.count != '0;
				e2 = s.ack_long.count != '0;
				c1 = bump(s.ack_short, now, cfg.short_window);
				c2 = bump(s.ack_long, now, cfg.long_window);
				s.ack_short = c1;
				s.ack_long = c2;
				over = (e1 && c1.count > {1'b0, cfg.ack_short_limit})
					|| (e2 && c2.count > {1'b0, cfg.ack_long_limit});
				if (over) begin
					s.blocked = 1'b1;
					s.block_until = now + {16'd0, cfg.block_ns};
					verdict = VERDICT_DROP;
					block_started = 1'b1;
				end
			end
		end
		nxt = s;
	end
endmodule

// ----- design/syn_flood_challenge_filter_unit.sv -----
// Top level of the SYN flood challenge filter.
// Each accepted header is handled in two steps: the slot record is read from the
// table memory as start is accepted, then updated and written back in ST_WORK,
// where the verdict is registered; busy is high in ST_WORK, so no new header is
// taken before the last one is through. The result appears on verdict/reply_ack/
// block_started with done high for one cycle. After reset the block sweeps the
// valid memory, one slot a cycle, with busy high; configuration writes are taken
// during the sweep. Results cannot be stalled by the receiver.
module syn_flood_challenge_filter_unit #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        is_ipv4_tcp,
	input  logic [15:0] dst_port,
	input  logic [31:0] src_addr,
	input  logic        flag_syn,
	input  logic        flag_ack,
	input  logic        flag_rst,
	input  logic [31:0] seq_num,
	input  logic [63:0] arrival_ns,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [31:0] reply_ack,
	output logic        block_started,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import sfcf_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WORK} state_t;

	state_t state_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] idx, idx_s1;
	logic filt, filt_s1;
	logic [31:0] addr_s1, seq_s1;
	logic syn_s1, ack_s1, rst_s1;
	logic [63:0] now_s1;
	logic accept;
	cfg_t cfg;
	slot_t rd_slot, nxt;
	logic rd_valid, hit, wr, wr_en;
	logic [1:0] v;
	logic [31:0] ra;
	logic bs;
	logic vram_we;
	logic [IW-1:0] vram_waddr;

	assign idx = IW'(src_addr ^ {16'd0, src_addr[31:16]});
	assign filt = is_ipv4_tcp && dst_port == FILTER_PORT;
	assign accept = start && !busy;
	assign busy = state_q != ST_IDLE;

	sfcf_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// Slot record memory and valid memory.
	assign wr_en = state_q == ST_WORK && filt_s1 && wr;
	sfcf_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
		.clk, .we(wr_en), .waddr(idx_s1), .wdata(nxt), .raddr(idx), .rdata(rd_slot)
	);

	assign vram_we = state_q == ST_CLEAR || wr_en;
	assign vram_waddr = state_q == ST_CLEAR ? clr_q : idx_s1;
	sfcf_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid (
		.clk, .we(vram_we), .waddr(vram_waddr), .wdata(state_q != ST_CLEAR),
		.raddr(idx), .rdata(rd_valid)
	);

	assign hit = rd_valid && rd_slot.addr == addr_s1;

	sfcf_logic u_logic (
		.cfg, .hit, .cur(rd_slot), .src_addr(addr_s1), .flag_syn(syn_s1),
		.flag_ack(ack_s1), .flag_rst(rst_s1), .seq_num(seq_s1), .now(now_s1),
		.nxt, .wr, .verdict(v), .reply_ack(ra), .block_started(bs)
	);

	// Capture the header word.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= idx;
			filt_s1 <= filt;
			addr_s1 <= src_addr;
			seq_s1 <= seq_num;
			syn_s1 <= flag_syn;
			ack_s1 <= flag_ack;
			rst_s1 <= flag_rst;
			now_s1 <= arrival_ns;
		end
	end

	// Sequence clearing sweep and the ST_WORK update; register results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done <= 1'b0;
			verdict <= VERDICT_PASS;
			reply_ack <= '0;
			block_started <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					verdict <= filt_s1 ? v : VERDICT_PASS;
					reply_ack <= filt_s1 ? ra : 32'd0;
					block_started <= filt_s1 && bs;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WORK |=> done) else $error("missing result strobe");
	a_one_per_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !done ##1 done) else $error("result not two edges after accept");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en) else $error("table write outside update");
	a_reply_only_chal: assert property (@(posedge clk) disable iff (!arst_n)
		done && verdict != VERDICT_CHAL |-> reply_ack == 32'd0)
		else $error("reply ack without challenge");
endmodule
